@@ rtl/eha_pkg.sv @@
package eha_pkg;

    localparam int MAX_HANDLES_DEF = 1024;
    localparam int MAX_KINDS_DEF   = 32;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 10;
    localparam int COMP_W   = 5;
    localparam int STATUS_W = 3;
    localparam int MASK_W   = 32;
    localparam int LIVE_W   = 11;

    localparam int IN_BITS  = CMD_W + ID_W + COMP_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + ID_W + 1 + MASK_W + LIVE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

endpackage

@@ rtl/eha_ram.sv @@
module eha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/entity_handle_allocator_top.sv @@
// Entity handle allocator with a component bit mask per handle.
// Input channel s_*: one command item per handshake (create, destroy, add
// component, remove component, query). Output channel m_*: exactly one
// result item per command, in command order.
// Each command passes through the states ST_IDLE and ST_EXEC: in the accept
// cycle the entry memory (alive flag and mask) and the free-stack memory are
// read; in ST_EXEC the read data is checked, the result is registered and any
// change is written back. Both memories have registered reads, and s_tready
// stays low in ST_EXEC, so a new command is not taken before the last result
// is in the output register that drives m_tvalid.
// A finished result waits in the output register while the next command is
// read. If the receiver keeps m_tready low, the block holds ST_EXEC (with
// no write-back) until the register frees, and s_tready stays low
// meanwhile.
// Reset clears the high-water mark, the free-stack pointer and all control
// state. The memories are not cleared; only entries that were written are
// ever used, so s_tready is high as soon as reset ends.
module entity_handle_allocator_top #(
    parameter int MAX_HANDLES = eha_pkg::MAX_HANDLES_DEF,
    parameter int MAX_KINDS   = eha_pkg::MAX_KINDS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // cmd[2:0], entity_id[12:3], component_id[17:13], zero fill above
    input  logic [eha_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[2:0], handle[12:3], alive[13], component_mask[45:14],
    // live_count[56:46], zero fill above
    output logic [eha_pkg::OUT_W-1:0] m_tdata
);

    import eha_pkg::*;

    localparam int AW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(MAX_HANDLES + 1);
    localparam int K  = MAX_KINDS;
    localparam int EW = K + 1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]       hw_reg, hw_next;
    logic [CW-1:0]       ft_reg, ft_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    // Input fields
    logic [CMD_W-1:0]     in_cmd;
    logic [ID_W-1:0]      in_id;
    logic [COMP_W-1:0]    in_comp;
    logic [AW+ID_W-1:0]   in_id_ext;

    assign in_cmd    = s_tdata[CMD_W-1:0];
    assign in_id     = s_tdata[CMD_W+ID_W-1:CMD_W];
    assign in_comp   = s_tdata[IN_BITS-1:CMD_W+ID_W];
    assign in_id_ext = {{AW{1'b0}}, in_id};

    // Memory ports
    logic          ent_re, ent_we, stk_re, stk_we;
    logic [AW-1:0] ent_raddr, ent_waddr, stk_raddr, stk_waddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic [AW-1:0] stk_wdata, stk_rdata;
    logic [CW-1:0] ft_dec;

    assign ft_dec    = ft_reg - {{(CW-1){1'b0}}, 1'b1};
    assign ent_raddr = in_id_ext[AW-1:0];
    assign stk_raddr = ft_dec[AW-1:0];

    eha_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_HANDLES)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .re   (ent_re),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    eha_ram #(
        .WIDTH(AW),
        .DEPTH(MAX_HANDLES)
    ) u_stack_ram (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .re   (stk_re),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // Command evaluation in ST_EXEC
    logic [STATUS_W-1:0] r_status;
    logic [AW-1:0]       r_handle;
    logic                r_use_new;
    logic                r_alive;
    logic [K-1:0]        r_mask;
    logic                x_ent_we, x_stk_we;
    logic [EW-1:0]       x_ent_wdata;
    logic [AW-1:0]       x_ent_waddr;
    logic [CW-1:0]       x_hw, x_ft;

    logic                cur_alive;
    logic [K-1:0]        cur_mask;
    logic [K-1:0]        bit_vec;
    logic                comp_ok;
    logic                handle_ok;
    logic [CW+ID_W-1:0]  id_wide, hw_wide;
    logic [COMP_W+7:0]   comp_wide;
    logic                stack_empty, table_full, stack_room;

    assign cur_alive   = ent_rdata[K];
    assign cur_mask    = ent_rdata[K-1:0];
    assign id_wide     = {{CW{1'b0}}, id_reg};
    assign hw_wide     = {{ID_W{1'b0}}, hw_reg};
    assign handle_ok   = (id_wide < hw_wide) && cur_alive;
    assign comp_wide   = {8'b0, comp_reg};
    assign comp_ok     = comp_wide < (COMP_W + 8)'(MAX_KINDS);
    assign bit_vec     = K'(1) << comp_reg;
    assign stack_empty = (ft_reg == '0);
    assign table_full  = (hw_reg == CW'(MAX_HANDLES));
    assign stack_room  = (ft_reg < CW'(MAX_HANDLES));

    always_comb begin
        r_status    = ST_OK;
        r_handle    = addr_reg;
        r_use_new   = 1'b0;
        r_alive     = 1'b1;
        r_mask      = cur_mask;
        x_ent_we    = 1'b0;
        x_ent_waddr = addr_reg;
        x_ent_wdata = {1'b1, {K{1'b0}}};
        x_stk_we    = 1'b0;
        x_hw        = hw_reg;
        x_ft        = ft_reg;
        if (cmd_reg == CMD_CREATE) begin
            r_use_new = 1'b1;
            r_mask    = '0;
            if (!stack_empty) begin
                r_handle    = stk_rdata;
                x_ft        = ft_dec;
                x_ent_we    = 1'b1;
                x_ent_waddr = stk_rdata;
            end else if (!table_full) begin
                r_handle    = hw_reg[AW-1:0];
                x_hw        = hw_reg + {{(CW-1){1'b0}}, 1'b1};
                x_ent_we    = 1'b1;
                x_ent_waddr = hw_reg[AW-1:0];
            end else begin
                r_status = ST_FULL;
                r_handle = '0;
                r_alive  = 1'b0;
            end
        end else if (!handle_ok) begin
            r_status = ST_INVALID;
            r_alive  = 1'b0;
            r_mask   = '0;
        end else begin
            unique case (cmd_reg)
                CMD_DESTROY: begin
                    r_alive     = 1'b0;
                    r_mask      = '0;
                    x_ent_we    = 1'b1;
                    x_ent_wdata = '0;
                    if (stack_room) begin
                        x_stk_we = 1'b1;
                        x_ft     = ft_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                end
                CMD_ADD: begin
                    if (!comp_ok) begin
                        r_status = ST_ABSENT;
                    end else if ((cur_mask & bit_vec) != '0) begin
                        r_status = ST_PRESENT;
                    end else begin
                        r_mask      = cur_mask | bit_vec;
                        x_ent_we    = 1'b1;
                        x_ent_wdata = {1'b1, cur_mask | bit_vec};
                    end
                end
                CMD_REMOVE: begin
                    if (!comp_ok || ((cur_mask & bit_vec) == '0)) begin
                        r_status = ST_ABSENT;
                    end else begin
                        r_mask      = cur_mask & ~bit_vec;
                        x_ent_we    = 1'b1;
                        x_ent_wdata = {1'b1, cur_mask & ~bit_vec};
                    end
                end
                default: begin
                    // Query and unused command codes only report.
                end
            endcase
        end
    end

    // Output field formatting
    logic [AW+ID_W-1:0]   handle_ext;
    logic [ID_W-1:0]      out_handle;
    logic [K+MASK_W-1:0]  mask_ext;
    logic [CW-1:0]        live_diff;
    logic [CW+LIVE_W-1:0] live_ext;
    logic [OUT_W-1:0]     result;

    assign handle_ext = {{ID_W{1'b0}}, r_handle};
    assign out_handle = r_use_new ? handle_ext[ID_W-1:0] : id_reg;
    assign mask_ext   = {{MASK_W{1'b0}}, r_mask};
    assign live_diff  = x_hw - x_ft;
    assign live_ext   = {{LIVE_W{1'b0}}, live_diff};
    assign result     = {{(OUT_W-OUT_BITS){1'b0}}, live_ext[LIVE_W-1:0],
                         mask_ext[MASK_W-1:0], r_alive, out_handle, r_status};

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        hw_next       = hw_reg;
        ft_next       = ft_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        addr_next     = addr_reg;
        comp_next     = comp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ent_re        = 1'b0;
        stk_re        = 1'b0;
        ent_we        = 1'b0;
        stk_we        = 1'b0;
        ent_waddr     = x_ent_waddr;
        ent_wdata     = x_ent_wdata;
        stk_waddr     = ft_reg[AW-1:0];
        stk_wdata     = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    id_next    = in_id;
                    addr_next  = in_id_ext[AW-1:0];
                    comp_next  = in_comp;
                    ent_re     = 1'b1;
                    stk_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The read data stays in the memory output registers while
                // the result waits for room.
                if (out_free) begin
                    ent_we        = x_ent_we;
                    stk_we        = x_stk_we;
                    hw_next       = x_hw;
                    ft_next       = x_ft;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hw_reg       <= '0;
            ft_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hw_reg       <= hw_next;
            ft_reg       <= ft_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        addr_reg    <= addr_next;
        comp_reg    <= comp_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
